FILE: rtl/dsgc_pkg.sv
`default_nettype none

package dsgc_pkg;

    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    localparam logic KIND_POP  = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_NOT_SURE   = 3'd1,
        VERDICT_PRIO_QUEUE = 3'd2,
        VERDICT_QUEUE      = 3'd3,
        VERDICT_STACK      = 3'd4
    } t_verdict;

    // Broadcast to every cell of the sorted row.
    typedef struct packed {
        logic push;
        logic pop;
        t_cnt count;
        t_val value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/data_structure_guess_checker.sv
`default_nettype none

// An accepted item waits in S_EVAL (RAM read of stack top / queue front,
// then compare) until the result register is free or being emptied; no new
// item is taken meanwhile, but one is taken while the previous result waits.
// Reset: sync, active low; sets all flags, clears count, queue head, overflow.
// Stores need no clearing pass; only written entries are ever used.
module data_structure_guess_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_value,
    input  wire logic        i_case_last,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_verdict,
    output logic             o_stack_consistent,
    output logic             o_queue_consistent,
    output logic             o_heap_consistent,
    output logic             o_overflowed,
    output logic             o_case_done
);

    import dsgc_pkg::*;

    typedef enum logic {S_IDLE, S_EVAL} t_state;

    // ------------------------------------------------------------------
    // Control and item registers
    // ------------------------------------------------------------------
    t_state   r_state,  n_state;
    t_cnt     r_count,  n_count;     // shared by stack, queue and heap
    t_addr    r_head,   n_head;      // queue front
    logic [2:0] r_flags, n_flags;    // bit 0 stack, 1 queue, 2 heap
    logic     r_ovf,    n_ovf;

    logic     r_kind,   n_kind;
    t_val     r_val,    n_val;
    logic     r_last,   n_last;
    logic     r_nonempty, n_nonempty;
    logic     r_heap_miss, n_heap_miss;

    logic     r_out_valid, n_out_valid;
    t_verdict r_verdict,   n_verdict;
    logic [2:0] r_out_flags, n_out_flags;
    logic     r_out_ovf,   n_out_ovf;
    logic     r_out_last,  n_out_last;

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    logic w_accept, w_full, w_empty, w_push, w_pop, w_load;
    t_val w_val;
    t_val w_stk_rd, w_fifo_rd;
    t_addr w_stk_wr_addr, w_stk_rd_addr, w_tail;
    logic [CNT_BITS:0] w_tail_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_val      = t_val'(i_value);
    assign w_full     = (r_count == t_cnt'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_push     = w_accept && (i_kind == KIND_PUSH) && !w_full;
    assign w_pop      = w_accept && (i_kind == KIND_POP) && !w_empty;

    // Result register free, or being emptied this cycle.
    assign w_load = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);

    // Stack: top sits at count-1, push lands at count.
    assign w_stk_wr_addr = t_addr'(r_count);
    assign w_stk_rd_addr = t_addr'(r_count - t_cnt'(1));

    // Queue tail = (head + count) mod DEPTH; the sum stays below 2*DEPTH.
    assign w_tail_sum = (CNT_BITS+1)'(r_head) + (CNT_BITS+1)'(r_count);
    assign w_tail = (w_tail_sum >= (CNT_BITS+1)'(DEPTH))
                  ? t_addr'(w_tail_sum - (CNT_BITS+1)'(DEPTH))
                  : t_addr'(w_tail_sum);

    dsgc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (w_stk_wr_addr),
        .i_wr_data (w_val),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_stk_rd_addr),
        .o_rd_data (w_stk_rd)
    );

    dsgc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (w_tail),
        .i_wr_data (w_val),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_head),
        .o_rd_data (w_fifo_rd)
    );

    // ------------------------------------------------------------------
    // Priority queue: row of cells kept in descending order. A push
    // inserts in one step (each cell looks at its left neighbor), a pop
    // shifts every cell one place toward slot 0.
    // ------------------------------------------------------------------
    t_cell_ctrl w_ctrl;
    t_val       w_cell_data [DEPTH];
    logic       w_cell_keep [DEPTH];

    assign w_ctrl.push  = w_push;
    assign w_ctrl.pop   = w_pop;
    assign w_ctrl.count = r_count;
    assign w_ctrl.value = w_val;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_val w_prev_data, w_next_data;
        logic w_prev_keep;
        if (g == 0) begin : g_first
            assign w_prev_data = w_val;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev_data = w_cell_data[g-1];
            assign w_prev_keep = w_cell_keep[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_next_data = '0;
        end else begin : g_nxt
            assign w_next_data = w_cell_data[g+1];
        end
        dsgc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_index     (t_addr'(g)),
            .i_prev_data (w_prev_data),
            .i_prev_keep (w_prev_keep),
            .i_next_data (w_next_data),
            .o_data      (w_cell_data[g]),
            .o_keep      (w_cell_keep[g])
        );
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic [2:0] w_flags_eval;
    logic [1:0] w_nflags;

    always_comb begin
        w_flags_eval = r_flags;
        if (r_kind == KIND_POP) begin
            if (!r_nonempty || (w_stk_rd != r_val)) begin
                w_flags_eval[0] = 1'b0;
            end
            if (!r_nonempty || (w_fifo_rd != r_val)) begin
                w_flags_eval[1] = 1'b0;
            end
            if (r_heap_miss) begin
                w_flags_eval[2] = 1'b0;
            end
        end
        w_nflags = 2'(w_flags_eval[0]) + 2'(w_flags_eval[1]) + 2'(w_flags_eval[2]);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_flags     = r_flags;
        n_ovf       = r_ovf;
        n_kind      = r_kind;
        n_val       = r_val;
        n_last      = r_last;
        n_nonempty  = r_nonempty;
        n_heap_miss = r_heap_miss;
        n_out_valid = r_out_valid;
        n_verdict   = r_verdict;
        n_out_flags = r_out_flags;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state     = S_EVAL;
                    n_kind      = i_kind;
                    n_val       = w_val;
                    n_last      = i_case_last;
                    n_nonempty  = !w_empty;
                    n_heap_miss = w_empty || (w_cell_data[0] != w_val);
                    if (i_kind == KIND_PUSH) begin
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_count = r_count + t_cnt'(1);
                        end
                    end else if (!w_empty) begin
                        n_count = r_count - t_cnt'(1);
                        n_head  = (r_head == t_addr'(DEPTH - 1)) ? '0
                                                                : r_head + t_addr'(1);
                    end
                end
            end
            S_EVAL: begin
                if (w_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_flags = w_flags_eval;
                    n_out_ovf   = r_ovf;
                    n_out_last  = r_last;
                    n_flags     = w_flags_eval;
                    if (w_nflags > 2'd1) begin
                        n_verdict = VERDICT_NOT_SURE;
                    end else if (w_nflags == 2'd0) begin
                        n_verdict = VERDICT_IMPOSSIBLE;
                    end else if (w_flags_eval[2]) begin
                        n_verdict = VERDICT_PRIO_QUEUE;
                    end else if (w_flags_eval[1]) begin
                        n_verdict = VERDICT_QUEUE;
                    end else begin
                        n_verdict = VERDICT_STACK;
                    end
                    // end of case: back to the empty state
                    if (r_last) begin
                        n_count = '0;
                        n_head  = '0;
                        n_flags = 3'b111;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_flags     <= 3'b111;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_flags     <= n_flags;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_kind      <= n_kind;
        r_val       <= n_val;
        r_last      <= n_last;
        r_nonempty  <= n_nonempty;
        r_heap_miss <= n_heap_miss;
        r_verdict   <= n_verdict;
        r_out_flags <= n_out_flags;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_verdict          = r_verdict;
    assign o_stack_consistent = r_out_flags[0];
    assign o_queue_consistent = r_out_flags[1];
    assign o_heap_consistent  = r_out_flags[2];
    assign o_overflowed       = r_out_ovf;
    assign o_case_done        = r_out_last;

`ifndef NO_ASSERTIONS
    // Occupancy never passes the store size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("occupancy above store depth");

    // Queue head stays inside the store.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= t_addr'(DEPTH - 1))
        else $error("queue head out of range");

    // Slot 0 is not below slot 1 whenever two or more slots are occupied.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= t_cnt'(2)) |-> (w_cell_data[0] >= w_cell_data[1]))
        else $error("sorted row out of order");

    // Finishing a case item returns all case state to empty.
    a_case_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_last) |=> (r_count == '0 && r_flags == 3'b111 && !r_ovf
                                && r_head == '0))
        else $error("case state not cleared");
`endif

endmodule

`default_nettype wire

FILE: rtl/dsgc_ram.sv
`default_nettype none

module dsgc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dsgc_cell.sv
`default_nettype none

// One slot of the descending sorted row. Slot 0 holds the maximum.
module dsgc_cell (
    input  wire logic                   i_clk,
    input  wire dsgc_pkg::t_cell_ctrl   i_ctrl,
    input  wire dsgc_pkg::t_addr        i_index,
    input  wire dsgc_pkg::t_val         i_prev_data,
    input  wire logic                   i_prev_keep,
    input  wire dsgc_pkg::t_val         i_next_data,
    output dsgc_pkg::t_val              o_data,
    output logic                        o_keep
);

    import dsgc_pkg::*;

    t_val r_data;
    t_val n_data;
    logic w_valid;

    assign w_valid = t_cnt'(i_index) < i_ctrl.count;
    // Slot stays put on insert: it is occupied and not below the new value.
    assign o_keep  = w_valid && (r_data >= i_ctrl.value);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.push) begin
            if (o_keep) begin
                n_data = r_data;
            end else if (i_prev_keep) begin
                n_data = i_ctrl.value;
            end else begin
                n_data = i_prev_data;
            end
        end else if (i_ctrl.pop) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

FILE: dv/dsgc_order_checker.sv
`default_nettype none

// Watches both channels, runs its own stack, queue and max priority queue on
// every accepted item, and compares each result against the oldest report due.
module dsgc_order_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_value,
    input  wire logic        i_case_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_verdict,
    input  wire logic        i_stack_consistent,
    input  wire logic        i_queue_consistent,
    input  wire logic        i_heap_consistent,
    input  wire logic        i_overflowed,
    input  wire logic        i_case_done,
    output int               o_mismatches,
    output int               o_waiting,
    output int               o_checked
);

    import dsgc_pkg::*;

    localparam int STACK_BIT  = 0;
    localparam int QUEUE_BIT  = 1;
    localparam int HEAP_BIT   = 2;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        t_verdict verdict;
        logic     stack_ok;
        logic     queue_ok;
        logic     heap_ok;
        logic     overflow;
        logic     done;
    } t_report;

    t_val       lifo[$];
    t_val       fifo[$];
    t_val       prio[$];
    logic [2:0] order_ok      = 3'b111;
    logic       overflow_seen = 1'b0;
    t_report    reports_due[$];
    t_report    seen;
    t_report    want;
    int         mismatch_count = 0;
    int         pending_count  = 0;
    int         checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_waiting    = pending_count;
    assign o_checked    = checked_count;

    function automatic void clear_orders();
        lifo.delete();
        fifo.delete();
        prio.delete();
        order_ok      = 3'b111;
        overflow_seen = 1'b0;
    endfunction

    // Applies one operation to all three orders and returns the report it causes.
    function automatic t_report predict_report(input logic kind, input t_val v,
                                               input logic last);
        t_report rep;
        int      top_idx;
        if (kind == KIND_PUSH) begin
            // counts stay equal, so one size stands for all three
            if (lifo.size() >= DEPTH) begin
                overflow_seen = 1'b1;
            end else begin
                lifo.push_back(v);
                fifo.push_back(v);
                prio.push_back(v);
            end
        end else begin
            if (lifo.size() == 0 || lifo[$] != v) order_ok[STACK_BIT] = 1'b0;
            if (lifo.size() > 0) void'(lifo.pop_back());

            if (fifo.size() == 0 || fifo[0] != v) order_ok[QUEUE_BIT] = 1'b0;
            if (fifo.size() > 0) void'(fifo.pop_front());

            top_idx = 0;
            for (int k = 1; k < prio.size(); k++) begin
                if (prio[k] > prio[top_idx]) top_idx = k;
            end
            if (prio.size() == 0 || prio[top_idx] != v) order_ok[HEAP_BIT] = 1'b0;
            if (prio.size() > 0) prio.delete(top_idx);
        end

        case ($countones(order_ok))
            0: rep.verdict = VERDICT_IMPOSSIBLE;
            1: rep.verdict = order_ok[HEAP_BIT]  ? VERDICT_PRIO_QUEUE :
                             order_ok[QUEUE_BIT] ? VERDICT_QUEUE : VERDICT_STACK;
            default: rep.verdict = VERDICT_NOT_SURE;
        endcase
        rep.stack_ok = order_ok[STACK_BIT];
        rep.queue_ok = order_ok[QUEUE_BIT];
        rep.heap_ok  = order_ok[HEAP_BIT];
        rep.overflow = overflow_seen;
        rep.done     = last;
        if (last) clear_orders();
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_orders();
            reports_due.delete();
        end else begin
            // input first: a result taken at the same edge belongs to an older item
            if (i_in_valid && i_in_ready) begin
                reports_due.push_back(predict_report(i_kind, i_value, i_case_last));
            end
            if (i_out_valid && i_out_ready) begin
                seen.verdict  = t_verdict'(i_verdict);
                seen.stack_ok = i_stack_consistent;
                seen.queue_ok = i_queue_consistent;
                seen.heap_ok  = i_heap_consistent;
                seen.overflow = i_overflowed;
                seen.done     = i_case_done;
                if (reports_due.size() == 0) begin
                    if (mismatch_count < MAX_SHOWN)
                        $display("[%0t] result with no item pending: verdict %0d", $time,
                                 i_verdict);
                    mismatch_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (seen !== want) begin
                        if (mismatch_count < MAX_SHOWN)
                            $display({"[%0t] result %0d: expected verdict %0d s%b q%b h%b ",
                                      "ovf%b done%b, got verdict %0d s%b q%b h%b ovf%b done%b"},
                                     $time, checked_count, want.verdict, want.stack_ok,
                                     want.queue_ok, want.heap_ok, want.overflow, want.done,
                                     i_verdict, seen.stack_ok, seen.queue_ok, seen.heap_ok,
                                     seen.overflow, seen.done);
                        mismatch_count++;
                    end
                    checked_count++;
                end
            end
        end
        pending_count = reports_due.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

// Stimulus and verdict for the stack / queue / priority queue classifier.
// A short directed run hits each verdict and the empty-pop case, then random
// cases follow, most of them well-formed sequences in one chosen order with
// a few broken pops, plus one case that fills the store and pushes past it.
module tb_top;
    import dsgc_pkg::*;

    localparam int TARGET_ITEMS  = 1750;
    localparam int FULL_CASE_AT  = 400;   // items sent before the full-store case
    localparam int IDLE_LIMIT    = 1000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES  = 10;    // margin after the last pending result for strays

    // how pop claims are chosen within a case
    typedef enum int {
        ORD_STACK = 0,
        ORD_QUEUE = 1,
        ORD_PRIO  = 2,
        ORD_MIXED = 3
    } t_order;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        in_kind      = KIND_POP;
    logic [15:0] in_value     = '0;
    logic        in_last      = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [2:0]  verdict;
    logic        stack_consistent;
    logic        queue_consistent;
    logic        heap_consistent;
    logic        overflowed;
    logic        case_done;

    int          mismatches;
    int          waiting;
    int          checked;
    int          items_sent   = 0;
    int          cases_sent   = 0;
    int          idle_cycles  = 0;
    logic        steady       = 1'b0;   // no sender gaps for the current case
    t_val        case_vals[$];          // what the block holds now, in push order

    always #2 i_clk = ~i_clk;

    data_structure_guess_checker i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_kind             (in_kind),
        .i_value            (in_value),
        .i_case_last        (in_last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_verdict          (verdict),
        .o_stack_consistent (stack_consistent),
        .o_queue_consistent (queue_consistent),
        .o_heap_consistent  (heap_consistent),
        .o_overflowed       (overflowed),
        .o_case_done        (case_done)
    );

    dsgc_order_checker i_order_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_kind             (in_kind),
        .i_value            (in_value),
        .i_case_last        (in_last),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_verdict          (verdict),
        .i_stack_consistent (stack_consistent),
        .i_queue_consistent (queue_consistent),
        .i_heap_consistent  (heap_consistent),
        .i_overflowed       (overflowed),
        .i_case_done        (case_done),
        .o_mismatches       (mismatches),
        .o_waiting          (waiting),
        .o_checked          (checked)
    );

    // Watchdog: any handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side backpressure: ready runs of random length, mostly short
    // stalls, now and then a long one; a long ready run gives stall-free stretches.
    initial begin : result_sink
        int hold;
        int stall;
        int pick;
        forever begin
            @(negedge i_clk);
            out_ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 12);
            repeat (hold) @(negedge i_clk);
            pick  = $urandom_range(0, 99);
            stall = (pick < 70) ? $urandom_range(1, 2) :
                    (pick < 95) ? $urandom_range(3, 6) : $urandom_range(10, 30);
            out_ready <= 1'b0;
            repeat (stall - 1) @(negedge i_clk);
        end
    end

    // Sender gap before an item: usually none, sometimes a few, rarely long.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Tiny values make ties, so several orders can stay consistent together.
    function automatic t_val rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return t_val'($urandom_range(0, 3));
        if (pick == 5) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return t_val'($urandom_range(0, 16'hFFFF));
    endfunction

    // Removes the element that a pop in the given order would return and
    // claims it; an empty store gets a random claim.
    function automatic t_val take_claim(input t_order order);
        t_val v;
        int   idx;
        if (case_vals.size() == 0) return rand_value();
        case (order)
            ORD_STACK: v = case_vals.pop_back();
            ORD_QUEUE: v = case_vals.pop_front();
            default: begin
                idx = 0;
                for (int k = 1; k < case_vals.size(); k++) begin
                    if (case_vals[k] > case_vals[idx]) idx = k;
                end
                v = case_vals[idx];
                case_vals.delete(idx);
            end
        endcase
        return v;
    endfunction

    // Drives one item at the falling edge and holds it until it is taken.
    task automatic send_item(input logic kind, input t_val v, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_value <= v;
        in_last  <= last;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        if (last) cases_sent++;
    endtask

    // Push with shadow bookkeeping; a push into a full store is dropped.
    task automatic push_item(input t_val v, input logic last);
        if (case_vals.size() < DEPTH) case_vals.push_back(v);
        send_item(KIND_PUSH, v, last);
    endtask

    // One random case: an order is picked, pops mostly claim what that order
    // would return, a few claims are broken on purpose.
    task automatic run_case(input int n_ops);
        t_order order;
        t_val   v;
        logic   last;
        order  = t_order'($urandom_range(0, 3));
        steady = ($urandom_range(0, 3) == 0);
        case_vals.delete();
        for (int k = 0; k < n_ops; k++) begin
            last = (k == n_ops - 1);
            if ($urandom_range(0, 99) < 55) begin
                push_item(rand_value(), last);
            end else begin
                v = take_claim(order == ORD_MIXED ? t_order'($urandom_range(0, 2)) : order);
                if ((order == ORD_MIXED && $urandom_range(0, 1) == 1) ||
                    $urandom_range(0, 19) == 0)
                    v = rand_value();
                send_item(KIND_POP, v, last);
            end
        end
    endtask

    // Fills the store, pushes past it so the overflow flag sets, then pops
    // a handful in stack or queue order.
    task automatic run_full_case();
        t_order order;
        order  = $urandom_range(0, 1) ? ORD_STACK : ORD_QUEUE;
        steady = 1'b1;
        case_vals.delete();
        for (int k = 0; k < DEPTH + 3; k++) push_item(t_val'($urandom_range(0, 16'hFFFF)), 1'b0);
        for (int k = 0; k < 16; k++) send_item(KIND_POP, take_claim(order), k == 15);
    endtask

    initial begin : stimulus
        int full_cases;
        full_cases = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme values, only stack order survives
        case_vals.delete();
        push_item(16'hFFFF, 1'b0);
        push_item(16'h0000, 1'b0);
        send_item(KIND_POP, 16'h0000, 1'b0);
        send_item(KIND_POP, 16'hFFFF, 1'b1);
        // only queue order survives
        push_item(16'd1, 1'b0);
        push_item(16'd2, 1'b0);
        send_item(KIND_POP, 16'd1, 1'b0);
        send_item(KIND_POP, 16'd2, 1'b1);
        // only priority order survives
        push_item(16'd2, 1'b0);
        push_item(16'd3, 1'b0);
        push_item(16'd1, 1'b0);
        send_item(KIND_POP, 16'd3, 1'b0);
        send_item(KIND_POP, 16'd2, 1'b1);
        // all three agree
        push_item(16'd7, 1'b0);
        send_item(KIND_POP, 16'd7, 1'b1);
        // pop from an empty store clears every flag and stays that way
        send_item(KIND_POP, 16'h8000, 1'b0);
        push_item(16'd3, 1'b0);
        send_item(KIND_POP, 16'd3, 1'b1);
        // one-item cases: lone push, lone pop
        push_item(16'hAAAA, 1'b1);
        send_item(KIND_POP, 16'h5555, 1'b1);
        case_vals.delete();

        while (items_sent < TARGET_ITEMS) begin
            if (full_cases == 0 && items_sent >= FULL_CASE_AT) begin
                run_full_case();
                full_cases++;
            end else begin
                run_case($urandom_range(0, 4) == 0 ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24));
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d items in %0d cases (%0d filled past the store size).",
                 items_sent, cases_sent, full_cases);
        $display("Results checked: %0d, mismatches: %0d, still pending: %0d.",
                 checked, mismatches, waiting);
        if (mismatches == 0 && waiting == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
